### rtl/xorshift_uniform_gaussian_noise_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the xorshift noise source
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef XORSHIFT_UNIFORM_GAUSSIAN_NOISE_MACROS_SVH
`define XORSHIFT_UNIFORM_GAUSSIAN_NOISE_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define XUG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xug assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define XUG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xug assertion failed");
`else
`define XUG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define XUG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/xug_pkg.sv
// ---------------------------------------------------------------------------
// xug_pkg
// Types and constants shared by the xorshift uniform/Gaussian noise source.
// ---------------------------------------------------------------------------
package xug_pkg;

  // Output multiplier of the xorshift64* generator.
  localparam logic [63:0] MULT_CONST = 64'h2545_F491_4F6C_DD1D;

  // Shared multiplier: signed operands, wide enough for a 33-bit magnitude.
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_SEED        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 1'b1;

  // Request kinds.
  localparam logic KIND_UNIFORM  = 1'b0;
  localparam logic KIND_GAUSSIAN = 1'b1;

  // Input request.
  typedef struct packed {
    logic               kind;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
  } in_req_t;

  // Result request.
  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               saturated;
  } out_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_M0,
    S_M1,
    S_M2,
    S_WAIT,
    S_RANGE,
    S_GSUB,
    S_SCALE,
    S_FINISH
  } xug_state_t;

  // Meaning of the product currently held by the multiplier.
  typedef enum logic [1:0] {
    MT_NONE,
    MT_LO,
    MT_X1,
    MT_X2
  } mul_tag_t;

endpackage

### rtl/xug_mul.sv
// ---------------------------------------------------------------------------
// xug_mul
// Shared signed multiplier with a registered product and load enable.
// ---------------------------------------------------------------------------
module xug_mul
  import xug_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  // The product only changes when a new operation is issued, so a result
  // stays available until the sequencer consumes it.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/xug_rng.sv
// ---------------------------------------------------------------------------
// xug_rng
// xorshift64 state register with seed reload and one-step advance.
// ---------------------------------------------------------------------------
module xug_rng
  import xug_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [63:0] load_val,
  input  logic        step,
  output logic [63:0] state,
  output logic [63:0] state_adv
);

  logic [63:0] state_r;
  logic [63:0] state_nxt;
  logic [63:0] x1;
  logic [63:0] x2;

  // One xorshift step: shift right 12, left 25, right 27.
  always_comb begin
    x1        = state_r ^ (state_r >> 12);
    x2        = x1 ^ (x1 << 25);
    state_adv = x2 ^ (x2 >> 27);
  end

  // A seed write takes priority; a zero seed is replaced by one.
  always_comb begin
    state_nxt = state_r;
    if (load) begin
      state_nxt = (load_val == 64'd0) ? 64'd1 : load_val;
    end else if (step) begin
      state_nxt = state_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 64'd1;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

### rtl/xorshift_uniform_gaussian_noise.sv
// ---------------------------------------------------------------------------
// xorshift_uniform_gaussian_noise
// Uniform and sum-of-uniforms Gaussian noise source in signed fixed point.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall / in_data): one request per item.
//   Kind 0 returns a uniform value from value_a toward value_b; kind 1
//   returns value_a plus Gaussian noise scaled by noise_scale, saturated.
//   Result channel (out_valid / out_stall / out_data): one result per request.
//   Configuration (cfg_wen / cfg_index / cfg_wdata): index 0 reloads the
//   generator seed (zero loads one), index 1 sets noise_scale. Write only
//   while the block is idle.
// Sequencing
//   Each generator draw takes three passes through the one shared 32x32-class
//   multiplier. A uniform request steps through S_M0, S_M1, S_M2, S_WAIT,
//   S_RANGE and S_FINISH; a Gaussian request runs S_M0-S_M2 once per term
//   (GAUSS_TERMS draws), then S_WAIT, S_GSUB, S_SCALE and S_FINISH. The next
//   request is taken only after the block has returned to S_IDLE.
//   in_stall is high until the result has been written to the output register.
// Reset and stall
//   Reset loads seed 1, noise_scale 1.0 and clears the result valid flag.
//   A stalled result holds in the output register; a new request may be
//   accepted meanwhile, and its result waits until the register is free.
// ---------------------------------------------------------------------------
`include "xorshift_uniform_gaussian_noise_macros.svh"

module xorshift_uniform_gaussian_noise
  import xug_pkg::*;
#(
  parameter int GAUSS_TERMS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_data,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Derived widths.
  localparam int SUM_W = 32 + $clog2(GAUSS_TERMS);
  localparam int SHIFT = 32 - FRAC_BITS;
  localparam int G_W   = SUM_W + 1 - SHIFT;
  localparam int CNT_W = (GAUSS_TERMS > 1) ? $clog2(GAUSS_TERMS) : 1;
  localparam logic [SUM_W:0]   OFFSET    = (SUM_W + 1)'(GAUSS_TERMS) << 31;
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(GAUSS_TERMS - 1);

  // Control state.
  xug_state_t state_r;
  xug_state_t state_nxt;
  mul_tag_t   tag_r;
  mul_tag_t   issue_tag;
  logic [CNT_W-1:0] cnt_r;
  logic       out_valid_r;
  logic signed [31:0] ns_r;

  // Request and datapath registers.
  logic               kind_r;
  logic signed [31:0] a_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic [31:0]        upart_r;
  logic [31:0]        u_r;
  logic [SUM_W-1:0]   sum_r;
  logic signed [G_W-1:0] g_r;
  out_req_t           out_r;

  // Combinational signals.
  logic               in_accept;
  logic               out_free;
  logic               out_load;
  logic               seed_load;
  logic               ns_write;
  logic               rng_step;
  logic [63:0]        rng_state;
  logic [63:0]        rng_adv;
  logic               mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [32:0]        range_w;
  logic [32:0]        mag_w;
  logic [31:0]        u_w;
  logic [SUM_W:0]     g_full;
  logic [33:0]        uni_res;
  logic signed [PROD_W-1:0] noise;
  logic signed [PROD_W-1:0] total;
  logic               sat_hi;
  logic               sat_lo;
  out_req_t           res_w;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration decode.
  always_comb begin
    seed_load = 1'b0;
    ns_write  = 1'b0;
    if (cfg_wen) begin
      unique case (cfg_index)
        REG_SEED:        seed_load = 1'b1;
        REG_NOISE_SCALE: ns_write  = 1'b1;
        default: begin
          seed_load = 1'b0;
          ns_write  = 1'b0;
        end
      endcase
    end
  end

  xug_rng u_rng (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (seed_load),
    .load_val  (cfg_wdata),
    .step      (rng_step),
    .state     (rng_state),
    .state_adv (rng_adv)
  );

  xug_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_accept) state_nxt = S_M0;
      S_M0:     state_nxt = S_M1;
      S_M1:     state_nxt = S_M2;
      S_M2: begin
        if (kind_r == KIND_UNIFORM || cnt_r == CNT_LAST) begin
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_M0;
        end
      end
      S_WAIT:   state_nxt = (kind_r == KIND_GAUSSIAN) ? S_GSUB : S_RANGE;
      S_RANGE:  state_nxt = S_FINISH;
      S_GSUB:   state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, generator step, result load.
  // A draw's top word is lo*lo[63:32] plus the low words of both cross terms.
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    issue_tag = MT_NONE;
    rng_step  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_M0: begin
        rng_step  = 1'b1;
        mul_en    = 1'b1;
        mul_a     = {{(MUL_W-32){1'b0}}, rng_adv[31:0]};
        mul_b     = {{(MUL_W-32){1'b0}}, MULT_CONST[31:0]};
        issue_tag = MT_LO;
      end
      S_M1: begin
        mul_en    = 1'b1;
        mul_a     = {{(MUL_W-32){1'b0}}, rng_state[63:32]};
        mul_b     = {{(MUL_W-32){1'b0}}, MULT_CONST[31:0]};
        issue_tag = MT_X1;
      end
      S_M2: begin
        mul_en    = 1'b1;
        mul_a     = {{(MUL_W-32){1'b0}}, rng_state[31:0]};
        mul_b     = {{(MUL_W-32){1'b0}}, MULT_CONST[63:32]};
        issue_tag = MT_X2;
      end
      S_RANGE: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-32){1'b0}}, mag_r};
        mul_b  = {{(MUL_W-32){1'b0}}, u_r};
      end
      S_SCALE: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-G_W){g_r[G_W-1]}}, g_r};
        mul_b  = {{(MUL_W-32){ns_r[31]}}, ns_r};
      end
      S_FINISH: out_load = out_free;
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Range magnitude and direction of a uniform request.
  assign range_w = {in_data.value_b[31], in_data.value_b}
                 - {in_data.value_a[31], in_data.value_a};
  assign mag_w   = range_w[32] ? (33'd0 - range_w) : range_w;

  // Completed draw and centred Gaussian sum, reduced to the fraction width.
  assign u_w    = upart_r + prod[31:0];
  assign g_full = {1'b0, sum_r} - OFFSET;

  // Final result: uniform offset or scaled noise with saturation.
  always_comb begin
    uni_res = neg_r ? ({{2{a_r[31]}}, a_r} - {2'b00, prod[63:32]})
                    : ({{2{a_r[31]}}, a_r} + {2'b00, prod[63:32]});
    noise   = prod >>> FRAC_BITS;
    total   = noise + {{(PROD_W-32){a_r[31]}}, a_r};
    sat_hi  = !total[PROD_W-1] && (total[PROD_W-2:31] != '0);
    sat_lo  = total[PROD_W-1] && (total[PROD_W-2:31] != '1);
    if (kind_r == KIND_UNIFORM) begin
      res_w.sample_value = uni_res[31:0];
      res_w.saturated    = 1'b0;
    end else if (sat_hi) begin
      res_w.sample_value = 32'sh7FFF_FFFF;
      res_w.saturated    = 1'b1;
    end else if (sat_lo) begin
      res_w.sample_value = 32'sh8000_0000;
      res_w.saturated    = 1'b1;
    end else begin
      res_w.sample_value = total[31:0];
      res_w.saturated    = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tag_r       <= MT_NONE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ns_r        <= 32'sd65536;
    end else begin
      state_r <= state_nxt;
      tag_r   <= issue_tag;
      if (in_accept) begin
        cnt_r <= '0;
      end else if (state_r == S_M2 && cnt_r != CNT_LAST) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ns_write) begin
        ns_r <= cfg_wdata[31:0];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_data.kind;
      a_r    <= in_data.value_a;
      mag_r  <= mag_w[31:0];
      neg_r  <= range_w[32];
      sum_r  <= '0;
    end
    unique case (tag_r)
      MT_LO: upart_r <= prod[63:32];
      MT_X1: upart_r <= u_w;
      MT_X2: begin
        u_r   <= u_w;
        sum_r <= sum_r + {{(SUM_W-32){1'b0}}, u_w};
      end
      default: begin
        upart_r <= upart_r;
      end
    endcase
    if (state_r == S_GSUB) begin
      g_r <= g_full[SUM_W:SHIFT];
    end
    if (out_load) begin
      out_r <= res_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on sequencing and generator state.
  `XUG_ASSERT_NEXT(a_accept_stalls, clk, rst_n, in_accept, in_stall)
  `XUG_ASSERT_NEXT(a_lo_follows_m0, clk, rst_n, state_r == S_M0, tag_r == MT_LO)
  `XUG_ASSERT_SAME(a_rng_nonzero, clk, rst_n, 1'b1, rng_state != 64'd0)
  `XUG_ASSERT_NEXT(a_uniform_unsat, clk, rst_n, out_load && kind_r == KIND_UNIFORM, !out_r.saturated)

endmodule

### tb/xorshift_uniform_gaussian_noise_test.sv
// ---------------------------------------------------------------------------
// Testbench for the xorshift uniform/Gaussian noise source
// Drives uniform and Gaussian requests under several seed and noise-scale
// settings, with random gaps on the request side and random stalls on the
// result side. A local predictor of the generator works out each result,
// and the monitor compares every result field by field in order.
// ---------------------------------------------------------------------------
module xorshift_uniform_gaussian_noise_test;
  import xug_pkg::*;

  localparam int GAUSS_N = 12;
  localparam int FRAC_N = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQUESTS = 50;
  localparam longint S32_MAX = 64'sh7FFF_FFFF;
  localparam longint S32_MIN = -64'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_data;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEED;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: generator state and noise gain, as after reset.
  logic [63:0] gen_state = 64'd1;
  logic signed [31:0] noise_gain = 32'sd65536;

  in_req_t pending_requests[$];
  out_req_t expected_samples[$];
  int outstanding_requests = 0;
  int fail_count = 0;
  int cycle_count = 0;
  bit in_busy = 1'b1;
  bit out_busy = 1'b1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  xorshift_uniform_gaussian_noise #(
    .GAUSS_TERMS(GAUSS_N),
    .FRAC_BITS(FRAC_N)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // One xorshift64* step; the draw is the top half of the scrambled output.
  function automatic logic [31:0] next_draw();
    logic [63:0] x;
    logic [63:0] scrambled;
    x = gen_state;
    x ^= x >> 12;
    x ^= x << 25;
    x ^= x >> 27;
    gen_state = x;
    scrambled = x * MULT_CONST;
    return scrambled[63:32];
  endfunction

  // Works out the result of one request and advances the generator.
  function automatic out_req_t predict_sample(in_req_t req);
    longint a;
    longint span;
    longint q;
    longint total;
    longint g;
    longint noise;
    longint res;
    logic [63:0] mag;
    logic [63:0] prod;
    out_req_t r;
    a = $signed(req.value_a);
    r.saturated = 1'b0;
    if (req.kind == KIND_UNIFORM) begin
      // Step from value_a toward value_b by a fraction of the span.
      span = $signed(req.value_b) - a;
      mag = (span < 0) ? -span : span;
      prod = mag * next_draw();
      q = prod[63:32];
      res = (span < 0) ? a - q : a + q;
    end else begin
      // Centred sum of uniforms, reduced to the fixed-point grid, then scaled.
      total = 0;
      for (int k = 0; k < GAUSS_N; k++) begin
        total = total + next_draw();
      end
      g = total - GAUSS_N * 64'sd2147483648;
      g = g >>> (32 - FRAC_N);
      noise = (g * longint'(noise_gain)) >>> FRAC_N;
      res = a + noise;
      if (res > S32_MAX) begin
        res = S32_MAX;
        r.saturated = 1'b1;
      end else if (res < S32_MIN) begin
        res = S32_MIN;
        r.saturated = 1'b1;
      end
    end
    r.sample_value = res[31:0];
    return r;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(bit busy);
    int unsigned r;
    if (!busy) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] small_signed(int unsigned mag);
    logic [31:0] v;
    v = $urandom_range(0, mag);
    if ($urandom_range(0, 1) != 0) begin
      v = -v;
    end
    return v;
  endfunction

  // Operand values: extremes, small values and full-range values.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        return 32'h8000_0000;
      end
      1: begin
        return 32'h7FFF_FFFF;
      end
      2: begin
        return 32'h0000_0000;
      end
      3: begin
        return 32'hFFFF_FFFF;
      end
      4, 5: begin
        return small_signed(1 << 20);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: begin
        return 32'h7FFF_FFFF;
      end
      1: begin
        return 32'h8000_0000;
      end
      2: begin
        return 32'h0000_0000;
      end
      3, 4: begin
        return small_signed(1 << 19);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic queue_request(logic kind, logic [31:0] a, logic [31:0] b);
    in_req_t req;
    req.kind = kind;
    req.value_a = a;
    req.value_b = b;
    pending_requests.push_back(req);
    outstanding_requests++;
  endtask

  // Waits until every queued request has produced its result.
  task automatic drain();
    while (outstanding_requests != 0) begin
      @(posedge clk);
    end
  endtask

  // Register write while idle; the predictor takes the same setting.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_SEED) begin
      gen_state = (data == '0) ? 64'd1 : data;
    end else begin
      noise_gain = data[31:0];
    end
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Request driver: holds a stalled request, inserts gaps after acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(predict_sample(in_data));
        gap_left = pick_gap(in_busy);
      end
      if (in_valid && in_stall) begin
        // Request not yet taken: keep it unchanged.
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each result against the oldest expectation.
  always @(posedge clk) begin
    out_req_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("result with no request outstanding: sample_value %0d",
                 out_data.sample_value);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          outstanding_requests--;
          if (out_data.sample_value !== want.sample_value) begin
            $error("sample_value: expected %0d, got %0d",
                   want.sample_value, out_data.sample_value);
            fail_count++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b",
                   want.saturated, out_data.saturated);
            fail_count++;
          end
        end
      end
      // Start a stall now and then; hold it for its chosen length.
      if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(out_busy);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the overall cycle count.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] seed_value;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: uniform bound extremes, reversed and equal bounds, and Gaussian requests at the extremes.
    queue_request(KIND_UNIFORM, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(KIND_UNIFORM, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(KIND_UNIFORM, 32'd5, 32'd5);
    queue_request(KIND_UNIFORM, 32'd0, 32'd1);
    queue_request(KIND_UNIFORM, 32'hFFFF_FFFF, 32'd0);
    queue_request(KIND_GAUSSIAN, 32'd0, $urandom);
    queue_request(KIND_GAUSSIAN, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_request(KIND_GAUSSIAN, 32'h8000_0000, 32'd0);
    drain();

    // Largest positive gain: clipping at both ends.
    write_reg(REG_NOISE_SCALE, {$urandom, 32'h7FFF_FFFF});
    queue_request(KIND_GAUSSIAN, 32'h7FFF_FFFF, $urandom);
    queue_request(KIND_GAUSSIAN, 32'h8000_0000, $urandom);
    queue_request(KIND_GAUSSIAN, 32'd0, $urandom);
    drain();

    // Most negative gain.
    write_reg(REG_NOISE_SCALE, 64'h0000_0000_8000_0000);
    queue_request(KIND_GAUSSIAN, 32'h7FFF_FFFF, $urandom);
    queue_request(KIND_GAUSSIAN, 32'h8000_0000, $urandom);
    queue_request(KIND_GAUSSIAN, 32'd0, $urandom);
    drain();

    // Zero gain returns the centre; upper data bits must be ignored.
    write_reg(REG_NOISE_SCALE, 64'hFFFF_FFFF_0000_0000);
    queue_request(KIND_GAUSSIAN, 32'h1234_5678, $urandom);
    drain();

    // A zero seed must load one; then the all-ones seed.
    write_reg(REG_SEED, 64'd0);
    queue_request(KIND_UNIFORM, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(KIND_GAUSSIAN, 32'd0, $urandom);
    drain();
    write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_NOISE_SCALE, 64'd65536);
    queue_request(KIND_UNIFORM, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(KIND_GAUSSIAN, 32'h0001_0000, $urandom);
    drain();

    // Random phases, each with its own seed, gain and idling pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: begin
          seed_value = 64'd0;
        end
        1: begin
          seed_value = 64'hFFFF_FFFF_FFFF_FFFF;
        end
        default: begin
          seed_value = {$urandom, $urandom};
        end
      endcase
      write_reg(REG_SEED, seed_value);
      write_reg(REG_NOISE_SCALE, {$urandom, pick_gain()});
      in_busy = (p % 4 != 1) && (p % 4 != 3);
      out_busy = (p % 4 != 2) && (p % 4 != 3);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        a = pick_value();
        if ($urandom_range(0, 2) == 0) begin
          b = a + small_signed(1 << 16);
        end else begin
          b = pick_value();
        end
        queue_request($urandom_range(0, 1) ? KIND_GAUSSIAN : KIND_UNIFORM, a, b);
      end
      drain();
    end

    // Let any stray result show up before the verdict.
    repeat (60) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("%0d results never arrived", expected_samples.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/xug_pkg.sv
rtl/xug_mul.sv
rtl/xug_rng.sv
rtl/xorshift_uniform_gaussian_noise.sv
tb/xorshift_uniform_gaussian_noise_test.sv
